// File: rtl/device_table_nth_match_core_assert.svh
// assertion macros shared by the device table rtl
// included by the controller and datapath files, needs no package
`ifndef DEVICE_TABLE_NTH_MATCH_CORE_ASSERT_SVH
`define DEVICE_TABLE_NTH_MATCH_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DTNM_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DTNM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: rtl/dtnm_pkg.sv
// shared types and constants for the device table with nth-match lookup
// used by the controller, the datapath and the top level
`default_nettype none

package dtnm_pkg;

    // operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_FIND   = 2'd2
    } op_t;

    // result status codes carried in m_tuser
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // entry layout: vendor, device id, bus, device number, function
    localparam int ENTRY_W = 48;
    // input item payload: entry fields plus instance request
    localparam int ITEM_W  = 53;
    localparam int INST_W  = 5;
    localparam int BDF_W   = 16;

    typedef struct packed {
        logic do_clear;
        logic do_insert;
        logic start_find;
        logic emit_simple;
        logic scan;
        logic emit_scan;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic scan_done;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/dtnm_ram.sv
// generic single write port, single read port ram with registered read
// no package dependency
`default_nettype none

module dtnm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  raddr,
    output logic      [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

// File: rtl/dtnm_ctrl.sv
// controller state machine: input handshake and find sequencing
// depends on dtnm_pkg and the assertion macro header
`default_nettype none
`include "device_table_nth_match_core_assert.svh"

module dtnm_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic [1:0]           s_op,
    input  wire dtnm_pkg::dp_status_t sts,
    output logic                      s_tready,
    output dtnm_pkg::dp_cmd_t         cmd
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    logic   is_find;

    assign s_tready = (state_reg == S_IDLE) && sts.out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_find  = (s_op == dtnm_pkg::OP_FIND);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && is_find) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.do_clear    = accept && (s_op == dtnm_pkg::OP_CLEAR);
        cmd.do_insert   = accept && (s_op == dtnm_pkg::OP_INSERT);
        cmd.start_find  = accept && is_find;
        cmd.emit_simple = accept && !is_find;
        cmd.scan        = (state_reg == S_SCAN);
        cmd.emit_scan   = (state_reg == S_SCAN) && sts.scan_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `DTNM_ASSERT_NOW(a_no_accept_in_scan, aclk, aresetn, state_reg == S_SCAN, !s_tready)
    `DTNM_ASSERT_NEXT(a_scan_holds, aclk, aresetn,
        (state_reg == S_SCAN) && !sts.scan_done, state_reg == S_SCAN)
endmodule

`default_nettype wire

// File: rtl/dtnm_datapath.sv
// datapath: entry store, fill count, find scan and result register
// depends on dtnm_pkg, dtnm_ram and the assertion macro header
`default_nettype none
`include "device_table_nth_match_core_assert.svh"

module dtnm_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dtnm_pkg::dp_cmd_t             cmd,
    input  wire logic [dtnm_pkg::ITEM_W-1:0]   item,
    output dtnm_pkg::dp_status_t               sts,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [1:0]                         m_status,
    output logic [dtnm_pkg::BDF_W-1:0]         m_bdf
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = dtnm_pkg::INST_W;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_addr_reg, scan_addr_next;
    logic [IW-1:0] seen_reg, seen_next;
    logic [IW-1:0] want_reg;
    logic [15:0]   vid_reg;
    logic [15:0]   did_reg;
    logic          rd_valid_reg, rd_valid_next;
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [dtnm_pkg::BDF_W-1:0] bdf_reg, bdf_next;

    logic [dtnm_pkg::ENTRY_W-1:0] rdata;
    logic full;
    logic addr_lt_count;
    logic issue;
    logic match;
    logic hit_now;
    logic wr_en;

    assign full          = (count_reg == CW'(TABLE_DEPTH));
    assign addr_lt_count = (scan_addr_reg < count_reg);
    assign match         = (rdata[15:0] == vid_reg) && (rdata[31:16] == did_reg);
    assign hit_now       = rd_valid_reg && match && (seen_reg == want_reg);
    assign issue         = cmd.scan && addr_lt_count && !hit_now;
    assign wr_en         = cmd.do_insert && !full;

    assign sts.out_free  = !m_valid_reg || m_tready;
    // done on a hit, or once every filled entry has been read back
    assign sts.scan_done = hit_now || (!rd_valid_reg && !addr_lt_count);

    dtnm_ram #(
        .WIDTH (dtnm_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (item[dtnm_pkg::ENTRY_W-1:0]),
        .re    (issue),
        .raddr (scan_addr_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        seen_next      = seen_reg;
        rd_valid_next  = 1'b0;
        if (cmd.do_clear) begin
            count_next = '0;
        end else if (wr_en) begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.start_find) begin
            scan_addr_next = '0;
            seen_next      = '0;
        end else if (cmd.scan) begin
            rd_valid_next = issue;
            if (issue) begin
                scan_addr_next = scan_addr_reg + 1'b1;
            end
            if (rd_valid_reg && match && !hit_now) begin
                seen_next = seen_reg + 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        bdf_next     = bdf_reg;
        if (cmd.emit_simple) begin
            m_valid_next = 1'b1;
            status_next  = (cmd.do_insert && full) ? dtnm_pkg::ST_FULL : dtnm_pkg::ST_OK;
            bdf_next     = '0;
        end else if (cmd.emit_scan) begin
            m_valid_next = 1'b1;
            status_next  = hit_now ? dtnm_pkg::ST_OK : dtnm_pkg::ST_NOT_FOUND;
            bdf_next     = hit_now ? rdata[47:32] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        seen_reg      <= seen_next;
        status_reg    <= status_next;
        bdf_reg       <= bdf_next;
        if (cmd.start_find) begin
            vid_reg  <= item[15:0];
            did_reg  <= item[31:16];
            want_reg <= item[dtnm_pkg::ITEM_W-1:dtnm_pkg::ENTRY_W];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_status = status_reg;
    assign m_bdf    = bdf_reg;

    `DTNM_ASSERT_NOW(a_out_empty_in_scan, aclk, aresetn, cmd.scan, !m_valid_reg)
    `DTNM_ASSERT_NOW(a_count_bounded, aclk, aresetn, 1'b1, count_reg <= CW'(TABLE_DEPTH))
    `DTNM_ASSERT_NOW(a_read_only_in_scan, aclk, aresetn, rd_valid_reg, cmd.scan)
endmodule

`default_nettype wire

// File: rtl/device_table_nth_match_core.sv
// Device table with nth-match lookup.
// Input channel s_*: one transaction per operation, s_tuser selects clear,
// insert or find; s_tdata carries the entry fields and the instance request.
// Output channel m_*: exactly one result transaction per input transaction,
// in order; m_tuser is the status, m_tdata the bus/device/function of a hit.
// Clear and insert answer directly: the result is registered at the edge that
// accepts the item and the next item may follow in the following cycle.
// Find walks the filled entries in insertion order, one RAM read per cycle,
// ending early at the requested match; its result is registered once the
// match is seen or every filled entry has been read back. The single read
// port of the entry store sets that pace. s_tready is low while a find is
// scanning.
// A new item is accepted while a result waits, provided the receiver takes
// that result in the same cycle; if m_tready stays low the result holds and
// s_tready drops until it is taken.
// Reset (aresetn low, synchronous) empties the table by clearing the fill
// count; entries beyond the count are never read, so the RAM needs no clear
// and the block accepts items in the first cycle after reset.
// Depends on dtnm_pkg, dtnm_ctrl, dtnm_datapath and dtnm_ram.
`default_nettype none

module device_table_nth_match_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // vendor_id[15:0], device_id[31:16], bus_number[39:32],
    // device_number[44:40], function_number[47:45], instance_req[52:48]
    input  wire logic [55:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // found_bus[7:0], found_device[12:8], found_function[15:13]
    output logic [15:0]      m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser
);
    dtnm_pkg::dp_cmd_t    cmd;
    dtnm_pkg::dp_status_t sts;

    dtnm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    dtnm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .item     (s_tdata[dtnm_pkg::ITEM_W-1:0]),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_status (m_tuser),
        .m_bdf    (m_tdata)
    );
endmodule

`default_nettype wire
